### hdl/kpf_pkg.sv
// Package for the keyed pool with oldest-first replacement.
// Holds field widths, the register reset value and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package kpf_pkg;

  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int STAMP_W  = 32;
  localparam int CFG_W    = 4;

  localparam logic [CFG_W-1:0] CACHE_SIZE_RST = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } kpf_state_e;

endpackage

### hdl/kpf_req_if.sv
// Request channel of the keyed pool: valid/ready handshake with mode, key, handle.
// Depends on kpf_pkg for the field widths.
`timescale 1ns / 1ps

interface kpf_req_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [kpf_pkg::KEY_W-1:0]     key;
  logic [kpf_pkg::HANDLE_W-1:0]  handle;

  modport source (output valid, output mode, output key, output handle, input ready);
  modport sink   (input valid, input mode, input key, input handle, output ready);
endinterface

### hdl/kpf_rsp_if.sv
// Response channel of the keyed pool: valid/ready handshake with the lookup outcome.
// Depends on kpf_pkg for the field widths.
`timescale 1ns / 1ps

interface kpf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [kpf_pkg::HANDLE_W-1:0]  found_handle;
  logic                          inserted;
  logic                          evicted;
  logic [kpf_pkg::HANDLE_W-1:0]  evicted_handle;

  modport source (output valid, output hit, output found_handle, output inserted,
                  output evicted, output evicted_handle, input ready);
  modport sink   (input valid, input hit, input found_handle, input inserted,
                  input evicted, input evicted_handle, output ready);
endinterface

### hdl/kpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/keyed_pool_fifo_evict.sv
// Top level of the keyed resource pool with oldest-first replacement.
// Depends on kpf_pkg, kpf_req_if, kpf_rsp_if and kpf_ram.
`timescale 1ns / 1ps

// Usage
//   req_i carries one request: mode 0 fetches the oldest entry whose key matches
//   and removes it; mode 1 stores (key, handle) unless the handle is already held,
//   evicting the oldest entry first when occupancy has reached cache_size.
//   rsp_o returns exactly one response per request, in request order.
//   cfg_we_i / cfg_wdata_i write the cache_size register (values 0 and above
//   POOL_DEPTH are clamped to 1 and POOL_DEPTH). Write it only while idle.
// Timing
//   A request is taken only in the idle state. The sequencer then streams all
//   POOL_DEPTH slots out of the entry RAM, one per cycle, through a single age
//   subtract-and-compare unit; each slot passes the registered RAM read before
//   the compare, and the decision step follows the end of the scan and loads
//   the response register. A new request is taken only after that decision,
//   once the sequencer is back in the idle state.
// Reset
//   rst_ni clears all valid bits, the stamp counter, the response valid flag and
//   sets cache_size to 8. Key, handle and stamp storage is not cleared.
// Backpressure
//   The response register holds a finished response until rsp_o.ready; the
//   next request is accepted meanwhile, and its decision step waits for the
//   response register to drain.
module keyed_pool_fifo_evict #(
  parameter int POOL_DEPTH = 8,
  parameter int KEY_WIDTH  = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [kpf_pkg::CFG_W-1:0]  cfg_wdata_i,
  kpf_req_if.sink                    req_i,
  kpf_rsp_if.source                  rsp_o
);

  import kpf_pkg::*;

  localparam int KW     = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
  localparam int IdxW   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CntW   = $clog2(POOL_DEPTH + 1);
  localparam int SzW    = (CntW > CFG_W) ? CntW : CFG_W;
  localparam int RamW   = KW + HANDLE_W + STAMP_W;

  // sequencer and request latch
  kpf_state_e           state_q, state_d;
  logic [CntW-1:0]      issue_cnt_q, issue_cnt_d;
  logic                 rvalid_q, rvalid_d;
  logic [IdxW-1:0]      ridx_q, ridx_d;
  logic                 mode_q;
  logic [KW-1:0]        key_q;
  logic [HANDLE_W-1:0]  handle_q;

  // scan trackers
  logic                 found_q, found_d;
  logic [IdxW-1:0]      best_idx_q, best_idx_d;
  logic [STAMP_W-1:0]   best_age_q, best_age_d;
  logic [HANDLE_W-1:0]  best_handle_q, best_handle_d;
  logic                 held_q, held_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 free_found_q, free_found_d;
  logic [IdxW-1:0]      free_idx_q, free_idx_d;

  // pool state
  logic [POOL_DEPTH-1:0] valid_q, valid_d;
  logic [STAMP_W-1:0]    next_stamp_q, next_stamp_d;
  logic [CFG_W-1:0]      cache_size_q;

  // response register
  logic                 out_valid_q, out_valid_d;
  logic                 out_hit_q, out_ins_q, out_ev_q;
  logic [HANDLE_W-1:0]  out_found_q, out_ev_handle_q;

  // entry RAM
  logic                 ram_we, ram_re;
  logic [IdxW-1:0]      ram_waddr;
  logic [RamW-1:0]      ram_wdata, ram_rdata;
  logic [KW-1:0]        rd_key;
  logic [HANDLE_W-1:0]  rd_handle;
  logic [STAMP_W-1:0]   rd_stamp;

  // shared age unit and decision terms
  logic [STAMP_W-1:0]   age;
  logic                 rd_valid, cand;
  logic [SzW-1:0]       cs_ext, eff_size;
  logic                 evict, dec_go, req_fire, store_ins;
  logic [IdxW-1:0]      ins_slot;

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  assign rd_key    = ram_rdata[RamW-1 -: KW];
  assign rd_handle = ram_rdata[HANDLE_W+STAMP_W-1 -: HANDLE_W];
  assign rd_stamp  = ram_rdata[STAMP_W-1:0];

  // one age subtract and compare per scanned slot; ties keep the lower slot
  assign age      = next_stamp_q - rd_stamp;
  assign rd_valid = valid_q[ridx_q];
  assign cand     = rd_valid && (mode_q || (rd_key == key_q));

  // clamp the configured size to 1 .. POOL_DEPTH
  always_comb begin
    cs_ext = SzW'(cache_size_q);
    if (cache_size_q == '0) begin
      eff_size = SzW'(1);
    end else if (cs_ext > SzW'(POOL_DEPTH)) begin
      eff_size = SzW'(POOL_DEPTH);
    end else begin
      eff_size = cs_ext;
    end
  end

  assign evict     = mode_q && !held_q && found_q && (SzW'(cnt_q) >= eff_size);
  assign store_ins = mode_q && !held_q;
  // lowest free slot once the victim is gone
  assign ins_slot  = (evict && (!free_found_q || (best_idx_q < free_idx_q))) ?
                     best_idx_q : free_idx_q;
  assign dec_go    = (state_q == S_DECIDE) && (!out_valid_q || rsp_o.ready);

  assign ram_re    = (state_q == S_SCAN) && (issue_cnt_q < CntW'(POOL_DEPTH));
  assign ram_we    = dec_go && store_ins;
  assign ram_waddr = ins_slot;
  assign ram_wdata = {key_q, handle_q, next_stamp_q};

  kpf_ram #(
    .WIDTH (RamW),
    .DEPTH (POOL_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (issue_cnt_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d       = state_q;
    issue_cnt_d   = issue_cnt_q;
    rvalid_d      = 1'b0;
    ridx_d        = ridx_q;
    found_d       = found_q;
    best_idx_d    = best_idx_q;
    best_age_d    = best_age_q;
    best_handle_d = best_handle_q;
    held_d        = held_q;
    cnt_d         = cnt_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    valid_d       = valid_q;
    next_stamp_d  = next_stamp_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          // start a fresh scan
          issue_cnt_d  = '0;
          found_d      = 1'b0;
          held_d       = 1'b0;
          cnt_d        = '0;
          free_found_d = 1'b0;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ram_re) begin
          issue_cnt_d = issue_cnt_q + CntW'(1);
          rvalid_d    = 1'b1;
          ridx_d      = issue_cnt_q[IdxW-1:0];
        end
        if (rvalid_q) begin
          if (cand && (!found_q || (age > best_age_q))) begin
            found_d       = 1'b1;
            best_idx_d    = ridx_q;
            best_age_d    = age;
            best_handle_d = rd_handle;
          end
          if (rd_valid) begin
            cnt_d = cnt_q + CntW'(1);
            if (rd_handle == handle_q) begin
              held_d = 1'b1;
            end
          end else if (!free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = ridx_q;
          end
        end else if (!ram_re) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (dec_go) begin
          out_valid_d = 1'b1;
          // drop the hit entry or the victim, then claim the insert slot
          if ((!mode_q && found_q) || evict) begin
            valid_d[best_idx_q] = 1'b0;
          end
          if (store_ins) begin
            valid_d[ins_slot] = 1'b1;
            next_stamp_d      = next_stamp_q + STAMP_W'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rvalid_q     <= 1'b0;
      valid_q      <= '0;
      next_stamp_q <= '0;
      cache_size_q <= CACHE_SIZE_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rvalid_q     <= rvalid_d;
      valid_q      <= valid_d;
      next_stamp_q <= next_stamp_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        cache_size_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    issue_cnt_q   <= issue_cnt_d;
    ridx_q        <= ridx_d;
    found_q       <= found_d;
    best_idx_q    <= best_idx_d;
    best_age_q    <= best_age_d;
    best_handle_q <= best_handle_d;
    held_q        <= held_d;
    cnt_q         <= cnt_d;
    free_found_q  <= free_found_d;
    free_idx_q    <= free_idx_d;
    if (req_fire) begin
      mode_q   <= req_i.mode;
      key_q    <= req_i.key[KW-1:0];
      handle_q <= req_i.handle;
    end
    if (dec_go) begin
      out_hit_q       <= !mode_q && found_q;
      out_found_q     <= (!mode_q && found_q) ? best_handle_q : '0;
      out_ins_q       <= store_ins;
      out_ev_q        <= evict;
      out_ev_handle_q <= evict ? best_handle_q : '0;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.hit            = out_hit_q;
  assign rsp_o.found_handle   = out_found_q;
  assign rsp_o.inserted       = out_ins_q;
  assign rsp_o.evicted        = out_ev_q;
  assign rsp_o.evicted_handle = out_ev_handle_q;

  // an insert bumps the stamp counter by exactly one
  a_stamp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_go && store_ins) |=> (next_stamp_q == $past(next_stamp_q) + STAMP_W'(1)))
    else $error("stamp counter did not advance on insert");

  // the insert slot is occupied after the decision
  a_ins_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_go && store_ins) |=> valid_q[$past(ins_slot)])
    else $error("inserted slot not marked valid");

  // an eviction always comes with an insert, never with a fetch hit
  a_evict_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (!rsp_o.evicted || (rsp_o.inserted && !rsp_o.hit)))
    else $error("eviction without insert");

  // a hit never coexists with an insert in one response
  a_hit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.hit && rsp_o.inserted))
    else $error("fetch hit and insert in one response");

endmodule

### dv/keyed_pool_fifo_evict_tb.sv
// Self-checking testbench for keyed_pool_fifo_evict: directed pool cases, then random traffic.
// Depends on kpf_pkg, kpf_req_if, kpf_rsp_if and the keyed_pool_fifo_evict RTL.
`timescale 1ns / 1ps

module keyed_pool_fifo_evict_tb;

  import kpf_pkg::*;

  localparam int POOL_DEPTH   = 8;
  localparam int KEY_WIDTH    = 32;
  // Margin before a register write: twice the request spacing of the block.
  localparam int DRAIN_CYCLES = 2 * (POOL_DEPTH + 4);

  typedef enum logic {
    MODE_FETCH = 1'b0,
    MODE_STORE = 1'b1
  } pool_mode_e;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] found_handle;
    logic                inserted;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;
  } pool_resp_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  kpf_req_if req_if ();
  kpf_rsp_if rsp_if ();

  keyed_pool_fifo_evict #(
    .POOL_DEPTH(POOL_DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Shadow copy of the pool contents, the stamp counter and the size register.
  logic                slot_valid  [POOL_DEPTH];
  logic [KEY_W-1:0]    slot_key    [POOL_DEPTH];
  logic [HANDLE_W-1:0] slot_handle [POOL_DEPTH];
  logic [STAMP_W-1:0]  slot_stamp  [POOL_DEPTH];
  logic [STAMP_W-1:0]  stamp_ctr;
  logic [CFG_W-1:0]    cache_size_q;

  // Responses owed by the block, oldest first.
  pool_resp_t pending_resp_q[$];

  int error_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Random content pools; small sets so that keys hit and handles repeat.
  logic [KEY_W-1:0]    key_set    [6];
  logic [HANDLE_W-1:0] handle_set [24];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run.
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] exp_val, logic [31:0] got_val);
    error_count++;
    $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, exp_val, got_val);
  endtask

  // Oldest valid slot, optionally restricted to a key; -1 if none.
  // Age is the wrapped distance back from the stamp counter; ties go to the lower slot.
  function automatic int oldest_slot(bit match_key, logic [KEY_W-1:0] key);
    int                 best;
    logic [STAMP_W-1:0] best_age;
    logic [STAMP_W-1:0] age;
    best     = -1;
    best_age = '0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (!slot_valid[i]) continue;
      if (match_key && slot_key[i] != key) continue;
      age = stamp_ctr - slot_stamp[i];
      if (best < 0 || age > best_age) begin
        best     = i;
        best_age = age;
      end
    end
    return best;
  endfunction

  // Apply one request to the shadow pool and return the response it must produce.
  function automatic pool_resp_t pool_outcome(pool_mode_e mode, logic [KEY_W-1:0] key,
                                              logic [HANDLE_W-1:0] handle);
    pool_resp_t r;
    int         sel;
    int         held_count;
    int         eff_size;
    int         free_slot;
    bit         already_held;
    r            = '0;
    held_count   = 0;
    already_held = 1'b0;
    free_slot    = -1;
    if (mode == MODE_FETCH) begin
      sel = oldest_slot(1'b1, key);
      if (sel >= 0) begin
        r.hit            = 1'b1;
        r.found_handle   = slot_handle[sel];
        slot_valid[sel]  = 1'b0;
      end
    end else begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
        if (slot_valid[i]) begin
          held_count++;
          if (slot_handle[i] == handle) already_held = 1'b1;
        end
      end
      if (!already_held) begin
        // Clamp the register: zero acts as one, anything above the depth as the depth.
        eff_size = (cache_size_q == 0) ? 1 : int'(cache_size_q);
        if (eff_size > POOL_DEPTH) eff_size = POOL_DEPTH;
        // Evict just one entry, even when the size was lowered under the occupancy.
        if (held_count >= eff_size) begin
          sel = oldest_slot(1'b0, '0);
          if (sel >= 0) begin
            r.evicted        = 1'b1;
            r.evicted_handle = slot_handle[sel];
            slot_valid[sel]  = 1'b0;
          end
        end
        for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
          if (!slot_valid[i]) free_slot = i;
        end
        if (free_slot >= 0) begin
          slot_valid[free_slot]  = 1'b1;
          slot_key[free_slot]    = key;
          slot_handle[free_slot] = handle;
          slot_stamp[free_slot]  = stamp_ctr;
          stamp_ctr              = stamp_ctr + STAMP_W'(1);
          r.inserted             = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Send one request. Start and end on a rising edge. Valid stays high afterwards
  // so back-to-back requests need no gap; the next call drops it only to idle.
  task automatic send_request(pool_mode_e mode, logic [KEY_W-1:0] key,
                              logic [HANDLE_W-1:0] handle);
    pool_resp_t owed;
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid  <= 1'b1;
    req_if.mode   <= mode;
    req_if.key    <= key;
    req_if.handle <= handle;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    owed           = pool_outcome(mode, key, handle);
    pending_resp_q = {pending_resp_q, owed};
  endtask

  // Drop valid and wait until every owed response has come back and the block is idle.
  task automatic drain_requests();
    req_if.valid <= 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write cache_size while idle; the write lands on the next rising edge.
  task automatic write_cache_size(logic [CFG_W-1:0] value);
    drain_requests();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    cache_size_q  = value;
  endtask

  // Check every response handshake against the oldest owed response; stall at random.
  initial begin
    pool_resp_t want;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pending_resp_q.size() == 0) begin
          report_mismatch("unexpected response", 32'h0, 32'h1);
        end else begin
          want = pending_resp_q.pop_front();
          if (rsp_if.hit !== want.hit)
            report_mismatch("hit", 32'(want.hit), 32'(rsp_if.hit));
          if (rsp_if.found_handle !== want.found_handle)
            report_mismatch("found_handle", 32'(want.found_handle),
                            32'(rsp_if.found_handle));
          if (rsp_if.inserted !== want.inserted)
            report_mismatch("inserted", 32'(want.inserted), 32'(rsp_if.inserted));
          if (rsp_if.evicted !== want.evicted)
            report_mismatch("evicted", 32'(want.evicted), 32'(rsp_if.evicted));
          if (rsp_if.evicted_handle !== want.evicted_handle)
            report_mismatch("evicted_handle", 32'(want.evicted_handle),
                            32'(rsp_if.evicted_handle));
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Empty pool, key and handle extremes, a repeated handle, and two entries with one key.
  task automatic test_fetch_store_basics();
    send_request(MODE_FETCH, 32'h0000_0000, 16'h0000);   // miss on an empty pool
    send_request(MODE_STORE, 32'h0000_0000, 16'h0000);
    send_request(MODE_STORE, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(MODE_STORE, 32'hFFFF_FFFF, 16'h0000);   // handle already held: no insert
    send_request(MODE_STORE, 32'h0000_0007, 16'h0001);
    send_request(MODE_STORE, 32'h0000_0007, 16'h0002);
    send_request(MODE_FETCH, 32'h0000_0007, 16'hFFFF);   // oldest of the two matches
    send_request(MODE_FETCH, 32'hFFFF_FFFF, 16'h0000);
  endtask

  // Register clamping and eviction of the oldest entry.
  task automatic test_size_clamp_and_eviction();
    // Zero acts as one: with two entries held, a store evicts one and inserts.
    write_cache_size(4'd0);
    send_request(MODE_STORE, 32'h0000_0003, 16'h0003);
    // Above the depth acts as the depth: fill the pool, then overflow it.
    write_cache_size(4'd15);
    for (int h = 10; h < 16; h++) send_request(MODE_STORE, 32'hA5A5_0000 + h, 16'(h));
    send_request(MODE_STORE, 32'h5A5A_5A5A, 16'h0010);
  endtask

  // Lower the size under the occupancy: a store evicts only one entry.
  task automatic test_size_lowered_while_full();
    write_cache_size(4'd2);
    send_request(MODE_STORE, 32'h1234_5678, 16'h0011);
    send_request(MODE_FETCH, 32'h1234_5678, 16'h0000);
  endtask

  // Random mix of fetches and stores drawn mostly from small key and handle sets.
  task automatic run_random_phase(int n_items, int idle_pct, int stall_pct,
                                  logic [CFG_W-1:0] size_value);
    pool_mode_e          mode;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    write_cache_size(size_value);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    foreach (key_set[i]) key_set[i] = $urandom();
    key_set[0] = '0;
    key_set[1] = '1;
    foreach (handle_set[i]) handle_set[i] = 16'($urandom());
    for (int n = 0; n < n_items; n++) begin
      mode   = ($urandom_range(99) < 55) ? MODE_STORE : MODE_FETCH;
      key    = ($urandom_range(99) < 85) ? key_set[$urandom_range(5)] : $urandom();
      handle = ($urandom_range(99) < 85) ? handle_set[$urandom_range(23)]
                                         : HANDLE_W'($urandom());
      send_request(mode, key, handle);
    end
    drain_requests();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(120, 0, 0, 4'd8);
    run_random_phase(120, 69, 0, 4'd1);
    run_random_phase(120, 0, 69, 4'($urandom_range(15)));
    run_random_phase(120, 17, 17, 4'd15);
    run_random_phase(40, 17, 17, 4'd3);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    req_if.valid  = 1'b0;
    req_if.mode   = MODE_FETCH;
    req_if.key    = '0;
    req_if.handle = '0;
    // Mirror the reset state: empty pool, stamp zero, size at its reset value.
    foreach (slot_valid[i]) begin
      slot_valid[i]  = 1'b0;
      slot_key[i]    = '0;
      slot_handle[i] = '0;
      slot_stamp[i]  = '0;
    end
    stamp_ctr    = '0;
    cache_size_q = CACHE_SIZE_RST;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fetch_store_basics();
    test_size_clamp_and_eviction();
    test_size_lowered_while_full();
    test_random_traffic();

    drain_requests();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### keyed_pool_fifo_evict.f
hdl/kpf_pkg.sv
hdl/kpf_req_if.sv
hdl/kpf_rsp_if.sv
hdl/kpf_ram.sv
hdl/keyed_pool_fifo_evict.sv
dv/keyed_pool_fifo_evict_tb.sv
